[hw/rtl/gaq_pkg.sv]
// gaq_pkg: shared types and constants for the group absmax int8 quantizer
// no dependencies
package gaq_pkg;

	localparam int unsigned QDIV_STEPS = 8;
	localparam logic [10:0] MAX_GROUPS = 11'd1024;

	typedef struct packed {
		logic       valid;
		logic       last;
		logic       vec_last;
	} qctl_t;

endpackage

[hw/rtl/group_absmax_int8_quantizer_unit.sv]
// group_absmax_int8_quantizer_unit: top level, group buffer memory, max tracking,
// scale and per-sample drain; depends on gaq_pkg and gaq_qdiv
//
// Samples are taken one per cycle while a group fills a synchronous buffer memory.
// After the last sample of a group, busy stays high while the group drains: the
// scale is computed first, then each result takes a memory read, a pass through
// the 8-step divider and an output state before the next sample is read. Results
// appear one cycle each with out_valid and cannot be stalled.
module group_absmax_int8_quantizer_unit #(
	parameter int unsigned GROUP_SIZE  = 32,
	parameter int unsigned SAMPLE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] sample,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	output logic        out_valid,
	output logic signed [7:0] quantized,
	output logic [30:0] group_scale,
	output logic        group_last,
	output logic        vector_last
);
	import gaq_pkg::*;

	localparam int unsigned AW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
	localparam int unsigned CW = $clog2(GROUP_SIZE + 1);
	localparam int unsigned MB = SAMPLE_BITS + 1;

	typedef enum logic [4:0] {
		ST_FILL  = 5'b00001,
		ST_SCALE = 5'b00010,
		ST_READ  = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} st_t;

	st_t st_q;
	logic [SAMPLE_BITS-1:0] mem [GROUP_SIZE];
	logic [SAMPLE_BITS-1:0] rd_s1;
	logic [CW-1:0] cnt_q;
	logic [MB-1:0] max_q;
	logic [10:0]   gin_q;
	logic [9:0]    gcnt_q;
	logic [30:0]   scale_q;
	logic [MB-1:0] scale_acc_q;
	logic [MB-1:0] scale_rem_q;
	logic [5:0]    scale_step_q;
	logic          vec_end_q;
	logic          div_start;
	logic          div_done;
	logic [7:0]    quot;
	logic [MB-1:0] in_mag;
	logic [MB-1:0] rd_mag;
	logic          rd_neg;
	logic [10:0]   geff;
	logic          wr_en;
	logic [MB-1:0] sc_q0;
	logic [MB-1:0] sc_r;
	logic [2:0]    sc_fix;

	function automatic logic [MB-1:0] mag_of(input logic [SAMPLE_BITS-1:0] v);
		logic [MB-1:0] e;
		e = {v[SAMPLE_BITS-1], v};
		return v[SAMPLE_BITS-1] ? (~e + 1'b1) : e;
	endfunction

	assign busy = (st_q != ST_FILL);
	assign cfg_ready = (st_q == ST_FILL);
	assign wr_en = start && !busy;
	assign in_mag = mag_of(sample[SAMPLE_BITS-1:0]);
	assign rd_mag = mag_of(rd_s1);
	assign rd_neg = rd_s1[SAMPLE_BITS-1];
	assign geff = (gin_q == 11'd0) ? 11'd1 : ((gin_q > MAX_GROUPS) ? MAX_GROUPS : gin_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[AW-1:0]] <= sample[SAMPLE_BITS-1:0];
		end
		rd_s1 <= mem[cnt_q[AW-1:0]];
	end

	assign div_start = (st_q == ST_READ) && (scale_step_q == 6'd1);

	gaq_qdiv #(.MAG_BITS(MB)) u_qdiv (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.mag(rd_mag), .max_mag(max_q), .done(div_done), .quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_FILL;
			cnt_q        <= '0;
			max_q        <= '0;
			gin_q        <= 11'd1;
			gcnt_q       <= '0;
			scale_step_q <= '0;
			vec_end_q    <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			out_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				gin_q <= cfg_data;
			end
			case (st_q)
				ST_FILL: begin
					if (wr_en) begin
						if (in_mag > max_q) begin
							max_q <= in_mag;
						end
						if (cnt_q == CW'(GROUP_SIZE - 1)) begin
							cnt_q        <= '0;
							st_q         <= ST_SCALE;
							scale_step_q <= 6'd3;
							vec_end_q    <= (11'(gcnt_q) + 11'd1) >= geff;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_SCALE: begin
					// (max + 63) / 127 by a shift series and a small correction
					if (scale_step_q == 6'd0) begin
						st_q         <= ST_READ;
						scale_step_q <= 6'd2;
					end else begin
						scale_step_q <= scale_step_q - 6'd1;
					end
				end
				ST_READ: begin
					if (scale_step_q == 6'd1) begin
						st_q <= ST_DIV;
					end
					scale_step_q <= scale_step_q - 6'd1;
				end
				ST_DIV: begin
					if (div_done) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					out_valid <= 1'b1;
					if (cnt_q == CW'(GROUP_SIZE - 1)) begin
						cnt_q  <= '0;
						max_q  <= '0;
						st_q   <= ST_FILL;
						gcnt_q <= vec_end_q ? 10'd0 : gcnt_q + 10'd1;
					end else begin
						cnt_q        <= cnt_q + 1'b1;
						st_q         <= ST_READ;
						scale_step_q <= 6'd2;
					end
				end
				default: st_q <= ST_FILL;
			endcase
		end
	end

	// x/127 is x/128 + x/128^2 + ..., the floored sum falls short by at most four
	assign sc_q0 = (scale_acc_q >> 7) + (scale_acc_q >> 14) + (scale_acc_q >> 21)
		+ (scale_acc_q >> 28);
	assign sc_r = scale_acc_q - (scale_rem_q << 7) + scale_rem_q;

	always_comb begin
		if (sc_r >= MB'(508)) begin
			sc_fix = 3'd4;
		end else if (sc_r >= MB'(381)) begin
			sc_fix = 3'd3;
		end else if (sc_r >= MB'(254)) begin
			sc_fix = 3'd2;
		end else if (sc_r >= MB'(127)) begin
			sc_fix = 3'd1;
		end else begin
			sc_fix = 3'd0;
		end
	end

	// scale datapath
	always_ff @(posedge clk) begin
		if (st_q == ST_SCALE) begin
			case (scale_step_q)
				6'd3: scale_acc_q <= max_q + MB'(63);
				6'd2: scale_rem_q <= sc_q0;
				6'd1: scale_q <= 31'(scale_rem_q + MB'(sc_fix));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT) begin
			quantized   <= rd_neg ? -$signed(quot) : $signed(quot);
			group_scale <= scale_q;
			group_last  <= (cnt_q == CW'(GROUP_SIZE - 1));
			vector_last <= vec_end_q && (cnt_q == CW'(GROUP_SIZE - 1));
		end
	end

	a_busy_no_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready) else $error("cfg accepted while busy");
	a_vec_last_grp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && vector_last) |-> group_last) else $error("vector_last without group_last");
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !group_last) |-> busy) else $error("result outside drain");
	a_q_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quantized != -8'sd128)) else $error("quantized out of range");

endmodule

[hw/rtl/gaq_qdiv.sv]
// gaq_qdiv: sequential restoring divider giving one rounded 8-bit quotient
// depends on gaq_pkg
module gaq_qdiv #(
	parameter int unsigned MAG_BITS = 33
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MAG_BITS-1:0] mag,
	input  logic [MAG_BITS-1:0] max_mag,
	output logic                done,
	output logic [7:0]          quot
);
	import gaq_pkg::*;

	localparam int unsigned NW = MAG_BITS + 9;

	logic [NW-1:0] den_q;
	logic [NW-1:0] rem_q;
	logic [7:0]    q_q;
	logic [3:0]    step_q;
	logic          run_q;
	logic [NW-1:0] trial;
	logic [NW-1:0] den_sh;

	// numerator m*254 + max, denominator 2*max, quotient fits in 8 bits
	assign den_sh = den_q << step_q[2:0];
	assign trial = rem_q - den_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= 4'(QDIV_STEPS - 1);
			end else if (run_q) begin
				if (step_q == 4'd0) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
				step_q <= step_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (NW'(mag) << 8) - (NW'(mag) << 1) + NW'(max_mag);
			den_q <= NW'(max_mag) << 1;
			q_q   <= '0;
		end else if (run_q) begin
			if (rem_q >= den_sh) begin
				rem_q <= trial;
				q_q[step_q[2:0]] <= 1'b1;
			end
		end
	end

	// all-zero group quantizes to zero
	assign quot = (den_q == '0) ? 8'd0 : ((q_q > 8'd127) ? 8'd127 : q_q);

endmodule
